// ===== design/tspc_pkg.sv =====
// Shared constants and helpers for the tile/sprite pixel compositor.
`default_nettype none
package tspc_pkg;
    localparam int SPRITE_COUNT = 128;
    localparam int SPR_IDX_W = $clog2(SPRITE_COUNT);

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_ROM    = 2'd1;
    localparam logic [1:0] FUNC_PROM   = 2'd2;
    localparam logic [1:0] FUNC_RENDER = 2'd3;

    localparam logic [0:0] CFG_COLOR_BANK  = 1'd0;
    localparam logic [0:0] CFG_FLIP_SCREEN = 1'd1;

    localparam logic [15:0] ADDR_FLIP = 16'hcc04;
    localparam logic [15:0] ADDR_BANK = 16'hcc05;

    // Resistor-weighted sum of three PROM bits.
    function automatic logic [7:0] dac3(input logic [2:0] b);
        dac3 = (b[0] ? 8'h21 : 8'h00) + (b[1] ? 8'h47 : 8'h00) + (b[2] ? 8'h97 : 8'h00);
    endfunction
endpackage
`default_nettype wire

// ===== design/tspc_gfx_rom.sv =====
// Graphics ROM: two planes, one read port with registered data for each plane.
`default_nettype none
module tspc_gfx_rom import tspc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        we,
    input  wire logic [13:0] waddr,
    input  wire logic [7:0]  wdata,
    input  wire logic [12:0] raddr,
    output logic      [7:0]  lo_q,
    output logic      [7:0]  hi_q
);
    logic [7:0] lo_mem [8192];
    logic [7:0] hi_mem [8192];

    always_ff @(posedge aclk) begin
        if (we && !waddr[13]) lo_mem[waddr[12:0]] <= wdata;
        if (we && waddr[13]) hi_mem[waddr[12:0]] <= wdata;
        lo_q <= lo_mem[raddr];
        hi_q <= hi_mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/tile_sprite_pixel_compositor_top.sv =====
// Top level of the tile/sprite pixel compositor: memories and render sequencer.
// Sequence: writes and loads complete at their transfer; a render raises m_valid after at most
// the tile fetch states, a read and check per sprite (and a pen state on a hit), palette, output.
// Throughput: one item at a time; the block is idle again in the cycle m_valid rises and
// s_ready stays low while a result waits. Reset (aresetn low, synchronous) clears registers,
// then a sweep clears tile, attribute and sprite RAMs before any transfer.
`default_nettype none
module tile_sprite_pixel_compositor_top import tspc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_data,
    input  wire logic [7:0]  s_pixel_x,
    input  wire logic [7:0]  s_pixel_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_red,
    output logic      [7:0]  m_green,
    output logic      [7:0]  m_blue
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_T_ADDR, S_T_RD, S_T_ROM, S_T_PEN,
        S_S_RD, S_S_CHK, S_S_PEN, S_PAL, S_OUT
    } state_t;

    state_t state_reg;
    logic [9:0] clr_reg;
    logic [1:0] bank_reg;
    logic flip_reg;
    logic [7:0] scroll_reg [32];

    // video RAMs with registered reads
    logic [7:0] code_mem [1024];
    logic [7:0] attr_mem [256];
    logic [31:0] spr_mem [128];
    logic [7:0] prom_mem [256];
    logic [7:0] code_q, attr_q, prom_q;
    logic [31:0] spr_q;

    logic [7:0] cx_reg, cy_reg, syy_reg;
    logic [7:0] tattr_reg, idx_reg;
    logic [1:0] tpen_reg;
    logic [2:0] bit_reg;
    logic [SPR_IDX_W-1:0] spr_reg;
    logic [7:0] sattr_reg;

    logic [12:0] rom_raddr;
    logic [7:0] rom_lo, rom_hi;
    logic [9:0] ti;
    logic acc;

    assign acc = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && (!m_valid || m_ready);
    assign ti = {syy_reg[7:3], cx_reg[7:3]};

    // sprite geometry on the registered table entry
    logic [7:0] sy, sx, s1, sa;
    logic big, skip, hit;
    logic [8:0] top, rx, ry;
    logic [3:0] rxf, ryf;
    assign sy = spr_q[7:0];
    assign s1 = spr_q[15:8];
    assign sa = spr_q[23:16];
    assign sx = spr_q[31:24];
    assign big = sa[7];
    assign skip = (sx == 8'd0 && sy == 8'hff) || (sx < 8'h40 && sa[4]) || (sx >= 8'hc0 && !sa[4]);
    assign top = (big ? 9'd240 : 9'd248) - {1'b0, sy};
    assign rx = {1'b0, cx_reg} - {1'b0, sx};
    assign ry = {1'b0, cy_reg} - top;
    assign hit = !skip && !rx[8] && !ry[8] &&
                 (big ? (rx[7:4] == 4'd0 && ry[7:4] == 4'd0) :
                        (rx[7:3] == 5'd0 && ry[7:3] == 5'd0));
    always_comb begin
        rxf = s1[6] ? (big ? 4'd15 - rx[3:0] : {1'b0, 3'd7 - rx[2:0]}) : rx[3:0];
        ryf = s1[7] ? (big ? 4'd15 - ry[3:0] : {1'b0, 3'd7 - ry[2:0]}) : ry[3:0];
    end

    logic [7:0] scode;
    logic [12:0] spr_addr;
    assign scode = {sa[6:5], s1[5:0]};
    assign spr_addr = big ? {scode, ryf[3], rxf[3], ryf[2:0]}
                          : {scode, 2'b00, ryf[2:0]};

    // tile fetch reads the attribute straight from the RAM output, valid from S_T_ROM on
    always_comb begin
        if (state_reg == S_S_CHK) rom_raddr = spr_addr;
        else rom_raddr = {({attr_q[6:5], code_q}), syy_reg[2:0]};
    end

    tspc_gfx_rom u_rom (
        .aclk(aclk), .we(acc && s_func == FUNC_ROM && !(|s_address[15:14])),
        .waddr(s_address[13:0]), .wdata(s_data), .raddr(rom_raddr),
        .lo_q(rom_lo), .hi_q(rom_hi)
    );

    logic [1:0] pen;
    assign pen = {rom_hi[bit_reg], rom_lo[bit_reg]};

    logic cpu_w;
    assign cpu_w = acc && s_func == FUNC_WRITE;

    // memories: clear sweep or CPU write; reads at sequencer addresses
    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            code_mem[clr_reg] <= 8'd0;
            attr_mem[clr_reg[7:0]] <= 8'd0;
            spr_mem[clr_reg[6:0]] <= 32'd0;
        end else if (cpu_w) begin
            if (s_address[15:10] == 6'b110001) code_mem[s_address[9:0]] <= s_data;
            if (s_address[15:8] == 8'hc1) attr_mem[s_address[7:0]] <= s_data;
            if (s_address[15:9] == 7'b1100001) begin
                case (s_address[1:0])
                    2'd0: spr_mem[s_address[8:2]][7:0] <= s_data;
                    2'd1: spr_mem[s_address[8:2]][15:8] <= s_data;
                    2'd2: spr_mem[s_address[8:2]][23:16] <= s_data;
                    default: spr_mem[s_address[8:2]][31:24] <= s_data;
                endcase
            end
        end
        if (acc && s_func == FUNC_PROM && s_address[15:8] == 8'd0)
            prom_mem[s_address[7:0]] <= s_data;
        code_q <= code_mem[ti];
        attr_q <= attr_mem[{ti[9:7], ti[4:0]}];
        spr_q <= spr_mem[spr_reg];
        prom_q <= prom_mem[idx_reg];
    end

    // sequencer and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            bank_reg <= 2'd0;
            flip_reg <= 1'b0;
            m_valid <= 1'b0;
            for (int i = 0; i < 32; i++) scroll_reg[i] <= 8'd0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == CFG_COLOR_BANK) bank_reg <= cfg_data;
                else flip_reg <= cfg_data[0];
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 10'd1;
                    if (&clr_reg) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc) begin
                        if (s_func == FUNC_WRITE) begin
                            if (s_address[15:5] == 11'b11000000100)
                                scroll_reg[s_address[4:0]] <= s_data + 8'd1;
                            if (s_address == ADDR_FLIP) flip_reg <= s_data[0];
                            if (s_address == ADDR_BANK) bank_reg <= s_data[1:0];
                        end
                        if (s_func == FUNC_RENDER) begin
                            cx_reg <= flip_reg ? ~s_pixel_x : s_pixel_x;
                            cy_reg <= flip_reg ? ~(s_pixel_y + 8'd16) : s_pixel_y + 8'd16;
                            state_reg <= S_T_ADDR;
                        end
                    end
                end
                S_T_ADDR: begin
                    syy_reg <= cy_reg + scroll_reg[cx_reg[7:3]];
                    state_reg <= S_T_RD;
                end
                S_T_RD: begin
                    bit_reg <= 3'd7 - cx_reg[2:0];
                    state_reg <= S_T_ROM;
                end
                S_T_ROM: begin
                    // code and attribute reads have landed; ROM read in flight
                    tattr_reg <= attr_q;
                    state_reg <= S_T_PEN;
                end
                S_T_PEN: begin
                    tpen_reg <= pen;
                    idx_reg <= {bank_reg, tattr_reg[3:0], pen};
                    spr_reg <= '0;
                    state_reg <= S_S_RD;
                end
                S_S_RD: state_reg <= S_S_CHK;
                S_S_CHK: begin
                    sattr_reg <= sa;
                    bit_reg <= 3'd7 - rxf[2:0];
                    if (hit) state_reg <= S_S_PEN;
                    else if (spr_reg == SPR_IDX_W'(SPRITE_COUNT - 1)) state_reg <= S_PAL;
                    else begin
                        spr_reg <= spr_reg + 1'b1;
                        state_reg <= S_S_RD;
                    end
                end
                S_S_PEN: begin
                    if (pen != 2'd0) begin
                        idx_reg <= {bank_reg, sattr_reg[3:0], pen};
                        state_reg <= S_PAL;
                    end else if (spr_reg == SPR_IDX_W'(SPRITE_COUNT - 1)) state_reg <= S_PAL;
                    else begin
                        spr_reg <= spr_reg + 1'b1;
                        state_reg <= S_S_RD;
                    end
                end
                S_PAL: begin
                    // priority tile overrides the sprite
                    if (tattr_reg[4] && tpen_reg != 2'd0)
                        idx_reg <= {bank_reg, tattr_reg[3:0], tpen_reg};
                    state_reg <= S_OUT;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            // the PROM read of S_OUT is registered at the same edge that raises m_valid
            if (state_reg == S_OUT) m_valid <= 1'b1;
        end
    end

    // S_OUT registers prom_q from idx_reg; the byte is valid when m_valid rises and
    // holds while the result waits, since no transfer is taken meanwhile
    assign m_red = dac3(prom_q[2:0]);
    assign m_green = dac3(prom_q[5:3]);
    assign m_blue = dac3({prom_q[7:6], 1'b0});

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red))) else $error("result dropped");
    a_clear_start: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == S_CLEAR)) else $error("no clear sweep");
`endif
endmodule
`default_nettype wire
